FILE: hw/rtl/l2tp_pkg.sv
// ----------------------------------------------------------------------------
// l2tp_pkg
// Shared types, constants and helpers for the Ethernet/IP/UDP/L2TPv2 header
// parser: frame limits, protocol codes, verdict codes and the result layout.
// ----------------------------------------------------------------------------
package l2tp_pkg;

    // Frame length limit and the byte position counter that covers it
    localparam int unsigned MAX_FRAME_BYTES = 65536;
    localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES + 1);

    // Protocol constants
    localparam logic [15:0] ETH_IPV4      = 16'h0800;
    localparam logic [15:0] ETH_IPV6      = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [6:0]  ETH_HDR       = 7'd14;
    localparam logic [6:0]  IP6_HDR_BYTES = 7'd40;
    localparam logic [3:0]  L2TP_BASE     = 4'd6;
    localparam logic [15:0] DEF_UDP_PORT  = 16'd1701;

    // L2TP flag bits in the first header byte
    localparam int unsigned FLAG_T = 7;
    localparam int unsigned FLAG_L = 6;
    localparam int unsigned FLAG_S = 3;
    localparam int unsigned FLAG_O = 1;

    // Verdict codes
    localparam logic [2:0] V_NOT_IP  = 3'd0;
    localparam logic [2:0] V_NOT_UDP = 3'd1;
    localparam logic [2:0] V_PORT    = 3'd2;
    localparam logic [2:0] V_CTRL    = 3'd3;
    localparam logic [2:0] V_DATA    = 3'd4;
    localparam logic [2:0] V_TRUNC   = 3'd5;

    // One accepted frame byte
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_byte_item;

    // Input register to parser core handshake
    typedef struct packed {
        logic       valid;
        t_byte_item item;
    } t_in_ctrl;

    // Result payload; first member is the top bit, so ether_kind lands lowest
    typedef struct packed {
        logic [16:0] hdr_bytes;
        logic [15:0] recv_seq;
        logic [15:0] send_seq;
        logic        seq_valid;
        logic [15:0] session_ident;
        logic [15:0] tunnel_ident;
        logic [3:0]  tunnel_version;
        logic [15:0] udp_dest;
        logic [15:0] udp_source;
        logic        over_ipv6;
        logic [15:0] ether_kind;
    } t_result_data;

    localparam int unsigned RES_W   = $bits(t_result_data);
    localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic [2:0]   verdict;
        t_result_data data;
    } t_result;

    // Fixed L2TP header length for a given flag byte
    function automatic logic [3:0] fixed_len(input logic [7:0] f);
        logic [3:0] n;
        n = L2TP_BASE;
        if (f[FLAG_L]) n = n + 4'd2;
        if (f[FLAG_S]) n = n + 4'd4;
        if (f[FLAG_O]) n = n + 4'd2;
        return n;
    endfunction

endpackage

FILE: hw/rtl/l2tp_in_stage.sv
// ----------------------------------------------------------------------------
// l2tp_in_stage
// Input register: holds one frame byte until the parser core takes it.
// ----------------------------------------------------------------------------
module l2tp_in_stage
    import l2tp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_byte_item i_item,
    input  logic       i_take,
    output t_in_ctrl   o_ctrl
);

    logic       r_valid;
    t_byte_item r_item;

    // free when empty or when the held byte leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_ctrl.valid = r_valid;
    assign o_ctrl.item  = r_item;

endmodule

FILE: hw/rtl/l2tp_parse_core.sv
// ----------------------------------------------------------------------------
// l2tp_parse_core
// Per-frame parse state: byte position, captured header fields and verdict.
// Each accepted byte updates the state; the last byte of a frame also
// produces the summary result and returns the state to its frame reset.
// ----------------------------------------------------------------------------
module l2tp_parse_core
    import l2tp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  t_in_ctrl    i_ctrl,
    input  logic        i_out_free,
    output logic        o_take,
    output logic        o_res_valid,
    output t_result     o_res
);

    // configuration
    logic [15:0] r_port;

    // frame state
    logic [POS_W-1:0] r_pos,    n_pos;
    logic [15:0]      r_ether,  n_ether;
    logic [6:0]       r_udp,    n_udp;
    logic [7:0]       r_flags,  n_flags;
    logic [7:0]       r_shift,  n_shift;
    logic [15:0]      r_src,    n_src;
    logic [15:0]      r_dst,    n_dst;
    logic [15:0]      r_tun,    n_tun;
    logic [15:0]      r_ses,    n_ses;
    logic [15:0]      r_ns,     n_ns;
    logic [15:0]      r_nr,     n_nr;
    logic [3:0]       r_ver,    n_ver;
    logic [15:0]      r_offs,   n_offs;
    logic [16:0]      r_hdr,    n_hdr;
    logic [2:0]       r_verdict, n_verdict;

    logic [7:0]       b;
    logic             last;
    logic             l2;

    assign b    = i_ctrl.item.data;
    assign last = i_ctrl.item.last;

    // a last byte waits for room in the result register
    assign o_take      = i_ctrl.valid && (!last || i_out_free);
    assign o_res_valid = o_take && last;

    // next-state for one byte
    always_comb begin
        logic [15:0]      word;
        logic [POS_W-1:0] r;
        logic [POS_W-1:0] k;
        logic [POS_W-1:0] j;
        logic [POS_W-1:0] base0;
        logic [POS_W-1:0] base1;
        logic [3:0]       n;
        logic [3:0]       ihl;

        word  = {r_shift, b};
        r     = r_pos - POS_W'(r_udp);
        k     = r - POS_W'(8);
        j     = k - POS_W'(1);
        base0 = r_flags[FLAG_L] ? POS_W'(4) : POS_W'(2);
        base1 = base0 + POS_W'(4);
        n     = fixed_len(r_flags);
        ihl   = (b[3:0] < 4'd5) ? 4'd5 : b[3:0];

        n_pos     = r_pos;
        n_ether   = r_ether;
        n_udp     = r_udp;
        n_flags   = r_flags;
        n_shift   = r_shift;
        n_src     = r_src;
        n_dst     = r_dst;
        n_tun     = r_tun;
        n_ses     = r_ses;
        n_ns      = r_ns;
        n_nr      = r_nr;
        n_ver     = r_ver;
        n_offs    = r_offs;
        n_hdr     = r_hdr;
        n_verdict = r_verdict;

        if (r_verdict == V_TRUNC && r_pos < POS_W'(MAX_FRAME_BYTES)) begin
            if (r_pos == POS_W'(12)) begin
                n_shift = b;
            end else if (r_pos == POS_W'(13)) begin
                n_ether = word;
                if (word == ETH_IPV6) begin
                    n_udp = ETH_HDR + IP6_HDR_BYTES;
                end else if (word != ETH_IPV4) begin
                    n_verdict = V_NOT_IP;
                end
            end else if (r_pos < POS_W'(13)) begin
                // MAC addresses: nothing captured
            end else if (r_ether == ETH_IPV4 && r_pos == POS_W'(14)) begin
                n_udp = ETH_HDR + {1'b0, ihl, 2'b00};
            end else if (r_ether == ETH_IPV4 && r_pos == POS_W'(23)) begin
                if (b != PROTO_UDP) n_verdict = V_NOT_UDP;
            end else if (r_ether != ETH_IPV4 && r_pos == POS_W'(20)) begin
                if (b != PROTO_UDP) n_verdict = V_NOT_UDP;
            end else if (r_udp != 7'd0 && r_pos >= POS_W'(r_udp)) begin
                // UDP header
                if (r == POS_W'(0) || r == POS_W'(2)) begin
                    n_shift = b;
                end else if (r == POS_W'(1)) begin
                    n_src = word;
                end else if (r == POS_W'(3)) begin
                    n_dst = word;
                    if (word != r_port) n_verdict = V_PORT;
                end else if (r < POS_W'(8)) begin
                    // length and checksum skipped
                end else if (k == POS_W'(0)) begin
                    n_flags = b;
                end else if (k == POS_W'(1)) begin
                    n_ver = b[3:0];
                end else begin
                    // L2TP fields move with the L, S and O flags
                    if (!k[0]) begin
                        n_shift = b;
                    end else if (j == base0) begin
                        n_tun = word;
                    end else if (j == base0 + POS_W'(2)) begin
                        n_ses = word;
                    end else if (r_flags[FLAG_S]) begin
                        if (j == base1) begin
                            n_ns = word;
                        end else if (j == base1 + POS_W'(2)) begin
                            n_nr = word;
                        end else if (r_flags[FLAG_O] && j == base1 + POS_W'(4)) begin
                            n_offs = word;
                        end
                    end else if (r_flags[FLAG_O] && j == base1) begin
                        n_offs = word;
                    end
                    // end of the fixed header decides the verdict
                    if (k == POS_W'(n) - POS_W'(1)) begin
                        n_hdr = 17'(n) + (r_flags[FLAG_O] ? {1'b0, n_offs} : 17'd0);
                        n_verdict = r_flags[FLAG_T] ? V_CTRL : V_DATA;
                    end
                end
            end
        end

        if (r_pos < POS_W'(MAX_FRAME_BYTES)) n_pos = r_pos + POS_W'(1);
    end

    // result from the state after this byte
    assign l2 = (n_verdict == V_CTRL) || (n_verdict == V_DATA);

    always_comb begin
        o_res.verdict             = n_verdict;
        o_res.data.ether_kind     = n_ether;
        o_res.data.over_ipv6      = (n_ether == ETH_IPV6);
        o_res.data.udp_source     = n_src;
        o_res.data.udp_dest       = n_dst;
        o_res.data.tunnel_version = n_ver;
        o_res.data.tunnel_ident   = n_tun;
        o_res.data.session_ident  = n_ses;
        o_res.data.seq_valid      = l2 && n_flags[FLAG_S];
        o_res.data.send_seq       = n_ns;
        o_res.data.recv_seq       = n_nr;
        o_res.data.hdr_bytes      = l2 ? n_hdr : 17'd0;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port <= DEF_UDP_PORT;
        end else if (i_cfg_valid) begin
            r_port <= i_cfg_data;
        end
    end

    // frame state: cleared by reset and after every last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && last)) begin
            r_pos     <= '0;
            r_ether   <= '0;
            r_udp     <= '0;
            r_flags   <= '0;
            r_shift   <= '0;
            r_src     <= '0;
            r_dst     <= '0;
            r_tun     <= '0;
            r_ses     <= '0;
            r_ns      <= '0;
            r_nr      <= '0;
            r_ver     <= '0;
            r_offs    <= '0;
            r_hdr     <= 17'(L2TP_BASE);
            r_verdict <= V_TRUNC;
        end else if (o_take) begin
            r_pos     <= n_pos;
            r_ether   <= n_ether;
            r_udp     <= n_udp;
            r_flags   <= n_flags;
            r_shift   <= n_shift;
            r_src     <= n_src;
            r_dst     <= n_dst;
            r_tun     <= n_tun;
            r_ses     <= n_ses;
            r_ns      <= n_ns;
            r_nr      <= n_nr;
            r_ver     <= n_ver;
            r_offs    <= n_offs;
            r_hdr     <= n_hdr;
            r_verdict <= n_verdict;
        end
    end

endmodule

FILE: hw/rtl/l2tp_out_reg.sv
// ----------------------------------------------------------------------------
// l2tp_out_reg
// Result register: holds one frame summary until the downstream side takes it.
// ----------------------------------------------------------------------------
module l2tp_out_reg
    import l2tp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // room when empty or when the held result is taken this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: hw/rtl/l2tp_over_udp_header_parser.sv
// ----------------------------------------------------------------------------
// l2tp_over_udp_header_parser
// Ethernet/IPv4-IPv6/UDP/L2TPv2 header parser, one frame byte per transfer,
// one summary result per frame on its last byte.
//
//   Channel  Dir  Handshake                     Payload
//   s_axis   in   s_axis_tvalid/s_axis_tready   tdata frame byte, tlast end
//   m_axis   out  m_axis_tvalid/m_axis_tready   tuser verdict, tdata fields
//   cfg      in   i_cfg_valid/o_cfg_ready       i_cfg_data UDP port
//
// One byte per cycle sustained unless a frame's last byte waits for room in
// the result register; each byte is held in the input register and then
// updates the parse state in the parser core. The result is loaded at the
// edge that takes the last byte from the input register.
// Reset (synchronous, active low) clears both registers and sets the port
// to 1701. A stalled result holds only a frame's last byte back; other
// bytes keep flowing while a result waits.
// ----------------------------------------------------------------------------
module l2tp_over_udp_header_parser
    import l2tp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    // frame bytes in
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] frame_byte
    input  logic               s_axis_tlast,   // frame_end
    // frame summary out
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // ether_kind, over_ipv6,
                                               // udp_source, udp_dest,
                                               // tunnel_version, tunnel_ident,
                                               // session_ident, seq_valid,
                                               // send_seq, recv_seq,
                                               // tunnel_header_bytes, pad
    output logic [2:0]         m_axis_tuser    // [2:0] verdict
);

    t_byte_item in_item;
    t_in_ctrl   in_ctrl;
    logic       take;
    logic       out_free;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign o_cfg_ready = 1'b1;

    assign in_item.data = s_axis_tdata;
    assign in_item.last = s_axis_tlast;

    // input register
    l2tp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (take),
        .o_ctrl  (in_ctrl)
    );

    // parse state and result logic
    l2tp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_ctrl      (in_ctrl),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    l2tp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = TDATA_W'(out_res.data);
    assign m_axis_tuser = out_res.verdict;

endmodule

FILE: hw/rtl/l2tp_checker.sv
// ----------------------------------------------------------------------------
// l2tp_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module l2tp_checker
    import l2tp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [TDATA_W-1:0] m_axis_tdata,
    input  logic [2:0]         m_axis_tuser
);

    t_result_data d;
    logic         l2;

    assign d  = m_axis_tdata[RES_W-1:0];
    assign l2 = (m_axis_tuser == V_CTRL) || (m_axis_tuser == V_DATA);

    // a stalled result holds still
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // sequence numbers flagged only on an L2TP verdict
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && d.seq_valid |-> l2)
        else $error("seq_valid without L2TP verdict");

    // header length reported only for L2TP, and at least the base length
    a_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (l2 ? (d.hdr_bytes >= 17'(L2TP_BASE)) : (d.hdr_bytes == 17'd0)))
        else $error("header length inconsistent with verdict");

    // IPv6 flag matches the EtherType
    a_v6: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (d.over_ipv6 == (d.ether_kind == ETH_IPV6)))
        else $error("over_ipv6 disagrees with ether_kind");

    // an IP-based verdict needs an IP EtherType
    a_ip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != V_NOT_IP && m_axis_tuser != V_TRUNC |->
            (d.ether_kind == ETH_IPV4) || (d.ether_kind == ETH_IPV6))
        else $error("IP verdict on non-IP frame");

endmodule

bind l2tp_over_udp_header_parser l2tp_checker u_l2tp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
